FILE: rtl/core/vpp_pkg.sv
// Shared types and constants of the VNNI pair-pack address generator.
package vpp_pkg;

  // Default parameter bounds
  localparam int MAX_DEPTH_DEF = 4096;
  localparam int MAX_COLS_DEF  = 4096;

  // Field widths
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 16;
  localparam int OFF_W   = 24;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Reset value of both size registers
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd64;

  // Register index, taken from paddr[2]
  localparam logic REG_COLS  = 1'b0;
  localparam logic REG_DEPTH = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture an accepted item
    logic decode;  // resolve panel, width and range
    logic mul;     // form the two products
    logic sum;     // add the products into the row base
    logic step;    // one result transferred, advance
  } vpp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_range;  // item lies inside the matrix
    logic last;      // current result is the item's final one
  } vpp_sts_t;

endpackage

FILE: rtl/core/vpp_regs.sv
// APB register file holding the column and depth counts.
module vpp_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [vpp_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [vpp_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [vpp_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output logic [vpp_pkg::CFG_W-1:0]    cols_r,
  output logic [vpp_pkg::CFG_W-1:0]    depth_r
);

  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= vpp_pkg::CFG_RESET;
      depth_r <= vpp_pkg::CFG_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[2] == vpp_pkg::REG_COLS) begin
        cols_r <= cfg_pwdata[vpp_pkg::CFG_W-1:0];
      end else begin
        depth_r <= cfg_pwdata[vpp_pkg::CFG_W-1:0];
      end
    end
  end

  // Read back the addressed register
  always_comb begin
    if (cfg_paddr[2] == vpp_pkg::REG_COLS) begin
      cfg_prdata = {{(vpp_pkg::DATA_W-vpp_pkg::CFG_W){1'b0}}, cols_r};
    end else begin
      cfg_prdata = {{(vpp_pkg::DATA_W-vpp_pkg::CFG_W){1'b0}}, depth_r};
    end
  end

endmodule

FILE: rtl/core/vpp_dpath.sv
// Datapath: panel decode, offset arithmetic and result sequencing.
module vpp_dpath #(
  parameter int MAX_DEPTH = vpp_pkg::MAX_DEPTH_DEF,
  parameter int MAX_COLS  = vpp_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  vpp_pkg::vpp_cmd_t           cmd,
  output vpp_pkg::vpp_sts_t           sts,
  input  logic [vpp_pkg::CFG_W-1:0]   cols_cfg,
  input  logic [vpp_pkg::CFG_W-1:0]   depth_cfg,
  input  logic [vpp_pkg::IDX_W-1:0]   depth_index,
  input  logic [vpp_pkg::IDX_W-1:0]   col_index,
  input  logic [vpp_pkg::VAL_W-1:0]   elem_value,
  output logic [vpp_pkg::OFF_W-1:0]   packed_offset,
  output logic [vpp_pkg::VAL_W-1:0]   packed_value,
  output logic                        is_pad,
  output logic                        last_write
);

  localparam int CW = vpp_pkg::CFG_W;
  localparam int IW = vpp_pkg::IDX_W;

  // Captured item
  logic [IW-1:0]              k_r, n_r;
  logic [vpp_pkg::VAL_W-1:0]  v_r;

  // Decoded panel geometry
  logic [CW-1:0]   ps_r;
  logic [CW:0]     kpad_r;
  logic [6:0]      w_r;
  logic            odd_tail_r, fringe_r;
  logic [3:0]      rem_r;

  // Products and base
  logic [CW+CW:0]               prod_r;
  logic [IW+7:0]                kw_r;
  logic [vpp_pkg::OFF_W-1:0]    base_r;

  // Result sequencer
  logic [5:0]  col_r;
  logic        first_r, phase_r;

  // Decode signals
  logic [CW-1:0]  nc, kc, full, ps_d;
  logic [5:0]     part, fr;
  logic [6:0]     w_d;
  logic           rem_panel, odd_tail_d, fringe_d, in_range;
  logic [5:0]     col_d;
  logic           slot, more_phase;

  // Saturate counts to the configured bounds
  always_comb begin
    nc = (32'(cols_cfg)  > MAX_COLS)  ? CW'(MAX_COLS)  : cols_cfg;
    kc = (32'(depth_cfg) > MAX_DEPTH) ? CW'(MAX_DEPTH) : depth_cfg;
  end

  // Resolve the panel of the captured column
  always_comb begin
    full      = {nc[CW-1:6], 6'd0};
    part      = nc[5:0];
    fr        = {part[5:4], 4'd0};
    rem_panel = 1'b0;
    if ({1'b0, n_r} < full) begin
      ps_d = {1'b0, n_r[IW-1:6], 6'd0};
      w_d  = 7'd64;
    end else if ({1'b0, n_r} < full + CW'(fr)) begin
      ps_d = full;
      w_d  = {1'b0, fr};
    end else begin
      ps_d      = full + CW'(fr);
      w_d       = 7'd16;
      rem_panel = 1'b1;
    end
    in_range   = ({1'b0, k_r} < kc) && ({1'b0, n_r} < nc);
    odd_tail_d = kc[0] && ({1'b0, k_r} == kc - CW'(1));
    fringe_d   = rem_panel && (part[3:0] != 4'd0) && ({1'b0, n_r} == nc - CW'(1));
    col_d      = 6'({1'b0, n_r} - ps_d);
  end

  // Pipeline the item through decode, multiply and sum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r <= depth_index;
      n_r <= col_index;
      v_r <= elem_value;
    end
    if (cmd.decode) begin
      ps_r       <= ps_d;
      kpad_r     <= {1'b0, kc} + {{CW{1'b0}}, kc[0]};
      w_r        <= w_d;
      odd_tail_r <= odd_tail_d;
      fringe_r   <= fringe_d;
      rem_r      <= part[3:0];
      col_r      <= col_d;
      first_r    <= 1'b1;
      phase_r    <= 1'b0;
    end
    if (cmd.mul) begin
      prod_r <= ps_r * kpad_r;
      kw_r   <= {(19'(k_r >> 1) * 19'(w_r)), 1'b0};
    end
    if (cmd.sum) begin
      base_r <= vpp_pkg::OFF_W'(prod_r) + vpp_pkg::OFF_W'(kw_r);
    end
    // Advance to the next write of the item
    if (cmd.step) begin
      if (more_phase) begin
        phase_r <= 1'b1;
      end else begin
        phase_r <= 1'b0;
        if (first_r) begin
          first_r <= 1'b0;
          col_r   <= {2'd0, rem_r};
        end else begin
          col_r <= col_r + 6'd1;
        end
      end
    end
  end

  // Form the current result
  always_comb begin
    more_phase    = !phase_r && odd_tail_r;
    slot          = phase_r ? 1'b1 : k_r[0];
    packed_offset = base_r + vpp_pkg::OFF_W'({col_r, slot});
    is_pad        = !(first_r && !phase_r);
    packed_value  = is_pad ? '0 : v_r;
    last_write    = !more_phase && (first_r ? !fringe_r : (col_r == 6'd15));
  end

  assign sts = {in_range, last_write};

endmodule

FILE: rtl/core/vpp_ctrl.sv
// Controller: sequences each in-range item through decode, multiply, sum and emit.
module vpp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output vpp_pkg::vpp_cmd_t  cmd,
  input  vpp_pkg::vpp_sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_SUM,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   in_xfer, out_xfer;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;
  assign in_xfer    = in_tvalid & in_tready_r;
  assign out_xfer   = out_tvalid_r & out_tready;

  // Drive datapath commands
  always_comb begin
    cmd.load   = in_xfer;
    cmd.decode = (state_r == S_DECODE);
    cmd.mul    = (state_r == S_MUL);
    cmd.sum    = (state_r == S_SUM);
    cmd.step   = out_xfer;
  end

  // Next state and registered handshake outputs
  always_comb begin
    state_nxt      = state_r;
    in_tready_nxt  = in_tready_r;
    out_tvalid_nxt = out_tvalid_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt     = S_DECODE;
          in_tready_nxt = 1'b0;
        end
      end
      S_DECODE: begin
        if (sts.in_range) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt     = S_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      S_MUL: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt      = S_EMIT;
        out_tvalid_nxt = 1'b1;
      end
      S_EMIT: begin
        if (out_xfer && sts.last) begin
          state_nxt      = S_IDLE;
          out_tvalid_nxt = 1'b0;
          in_tready_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt      = S_IDLE;
        in_tready_nxt  = 1'b1;
        out_tvalid_nxt = 1'b0;
      end
    endcase
  end

  // Hold state and handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready_r && out_tvalid_r))
    else $error("input ready while a result is pending");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready_r)
    else $error("input still ready after a transfer");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && sts.last) |=> (in_tready_r && !out_tvalid_r))
    else $error("block not idle after the final result");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> out_tvalid_r)
    else $error("emit state without a valid result");

endmodule

FILE: rtl/core/vnni_pair_pack_address.sv
// Top level of the VNNI pair-pack address generator for a bf16 B matrix.
// Each accepted element (k, n, value) yields its offset in the packed
// buffer, followed by any zero padding writes it owns: the odd-depth slot
// when KC is odd and k == KC-1, and the unused columns of the last 16-wide
// panel when the element sits in column NC-1. An item passes through
// decode, multiply and sum before its first result shows, then gives its
// results (1 to 32) one per cycle while out_tready is high; the next item
// is accepted only after the final result transfers, and an item outside
// KC x NC gives no result and frees the input from decode. A 13x14
// multiplier forms the panel start times the padded depth. Registers: column
// count at byte 0, depth count at byte 4, both reset to 64 and saturated to
// MAX_COLS and MAX_DEPTH; write them only while the block is idle.
module vnni_pair_pack_address #(
  parameter int MAX_DEPTH = vpp_pkg::MAX_DEPTH_DEF,
  parameter int MAX_COLS  = vpp_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [vpp_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [vpp_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [vpp_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [39:0]                 in_tdata,   // depth_index, col_index, elem_value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // packed_offset, packed_value
  output logic                        out_tuser,  // is_pad
  output logic                        out_tlast   // last_write
);

  vpp_pkg::vpp_cmd_t           cmd;
  vpp_pkg::vpp_sts_t           sts;
  logic [vpp_pkg::CFG_W-1:0]   cols_r, depth_r;
  logic [vpp_pkg::OFF_W-1:0]   packed_offset;
  logic [vpp_pkg::VAL_W-1:0]   packed_value;

  vpp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cols_r      (cols_r),
    .depth_r     (depth_r)
  );

  vpp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  vpp_dpath #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_COLS  (MAX_COLS)
  ) u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .cols_cfg      (cols_r),
    .depth_cfg     (depth_r),
    .depth_index   (in_tdata[11:0]),
    .col_index     (in_tdata[23:12]),
    .elem_value    (in_tdata[39:24]),
    .packed_offset (packed_offset),
    .packed_value  (packed_value),
    .is_pad        (out_tuser),
    .last_write    (out_tlast)
  );

  assign out_tdata = {packed_value, packed_offset};

endmodule
